FILE: rtl/irt_pkg.sv
// Shared status codes and queue sizing for the interval reservation table.
package irt_pkg;

  // Result codes carried on the status port
  typedef enum logic [1:0] {
    ST_BOOKED    = 2'd0,
    ST_CONFLICT  = 2'd1,
    ST_FULL      = 2'd2,
    ST_MALFORMED = 2'd3
  } status_t;

  // Depth of the queue between the front and back parts
  localparam int QDEPTH = 2;

endpackage

FILE: rtl/irt_queue.sv
// Short request queue between the classifier front and the scan back end.
module irt_queue #(
  parameter int WIDTH = 65
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             avail,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (irt_pkg::QDEPTH > 1) ? $clog2(irt_pkg::QDEPTH) : 1;
  localparam int CNT_W = $clog2(irt_pkg::QDEPTH + 1);

  logic [WIDTH-1:0] slots [irt_pkg::QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  logic do_push;
  logic do_pop;

  assign full     = (fill == CNT_W'(irt_pkg::QDEPTH));
  assign avail    = (fill != '0);
  assign pop_data = slots[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && avail;

  // Payload storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(irt_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(irt_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/irt_front.sv
// Front end: takes request beats, flags malformed intervals, feeds the queue.
module irt_front #(
  parameter int TIME_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [TIME_BITS-1:0]   start_time,
  input  logic [TIME_BITS-1:0]   end_time,
  output logic                   push,
  output logic [2*TIME_BITS:0]   push_data,
  input  logic                   q_full
);

  logic                 held;
  logic [TIME_BITS-1:0] held_start;
  logic [TIME_BITS-1:0] held_end;
  logic                 held_bad;
  logic                 take;

  assign in_stall  = held && q_full;
  assign take      = in_valid && !in_stall;
  assign push      = held && !q_full;
  assign push_data = {held_bad, held_start, held_end};

  // Holding register, payload part
  always_ff @(posedge clk) begin
    if (take) begin
      held_start <= start_time;
      held_end   <= end_time;
      // empty or reversed interval
      held_bad   <= (start_time >= end_time);
    end
  end

  // Holding register, valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (take) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

endmodule

FILE: rtl/irt_back.sv
// Back end: scans stored intervals from memory, books the request, drives the result.
module irt_back #(
  parameter int ENTRIES   = 64,
  parameter int TIME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_avail,
  input  logic [2*TIME_BITS:0] q_data,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           status
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t state;

  logic [TIME_BITS-1:0] slot_start [ENTRIES];
  logic [TIME_BITS-1:0] slot_end   [ENTRIES];

  logic [CNT_W-1:0]     booked_count;
  logic [CNT_W-1:0]     issue;
  logic                 rd_pending;
  logic [TIME_BITS-1:0] rd_start;
  logic [TIME_BITS-1:0] rd_end;
  logic                 conflict;
  logic [TIME_BITS-1:0] cur_start;
  logic [TIME_BITS-1:0] cur_end;
  irt_pkg::status_t     pend_status;
  irt_pkg::status_t     out_status;

  logic issue_more;
  logic scan_done;
  logic hit;
  logic do_book;
  logic out_free;

  assign issue_more = (issue < booked_count);
  assign scan_done  = (state == S_SCAN) && !issue_more && !rd_pending;
  assign hit        = rd_pending && (cur_start < rd_end) && (rd_start < cur_end);
  assign do_book    = scan_done && !conflict && (booked_count < CNT_W'(ENTRIES));
  assign out_free   = !out_valid || !out_stall;
  assign q_pop      = (state == S_IDLE) && q_avail;
  assign status     = out_status;

  // Interval memory: one registered read per cycle, one write at booking
  always_ff @(posedge clk) begin
    if (do_book) begin
      slot_start[booked_count[IDX_W-1:0]] <= cur_start;
      slot_end[booked_count[IDX_W-1:0]]   <= cur_end;
    end
    rd_start <= slot_start[issue[IDX_W-1:0]];
    rd_end   <= slot_end[issue[IDX_W-1:0]];
  end

  // Current request payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_start <= q_data[2*TIME_BITS-1:TIME_BITS];
      cur_end   <= q_data[TIME_BITS-1:0];
    end
  end

  // Sequencer: pop, scan, decide, hand off the result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      booked_count <= '0;
      issue        <= '0;
      rd_pending   <= 1'b0;
      conflict     <= 1'b0;
      pend_status  <= irt_pkg::ST_BOOKED;
      out_valid    <= 1'b0;
      out_status   <= irt_pkg::ST_BOOKED;
    end else begin
      // result beat taken; a new one in S_FINISH sets it again
      if (out_valid && !out_stall && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          issue      <= '0;
          rd_pending <= 1'b0;
          conflict   <= 1'b0;
          if (q_avail) begin
            if (q_data[2*TIME_BITS]) begin
              pend_status <= irt_pkg::ST_MALFORMED;
              state       <= S_FINISH;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          rd_pending <= issue_more;
          if (issue_more) begin
            issue <= issue + 1'b1;
          end
          if (hit) begin
            conflict <= 1'b1;
          end
          if (scan_done) begin
            if (conflict) begin
              pend_status <= irt_pkg::ST_CONFLICT;
            end else if (do_book) begin
              pend_status  <= irt_pkg::ST_BOOKED;
              booked_count <= booked_count + 1'b1;
            end else begin
              pend_status <= irt_pkg::ST_FULL;
            end
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_status <= pend_status;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // Table never holds more than its capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    booked_count <= CNT_W'(ENTRIES))
    else $error("booked count beyond table capacity");

  // Count only grows, by one, and only after a scan
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && (booked_count != $past(booked_count)) |->
      (booked_count == $past(booked_count) + 1'b1) && $past(state == S_SCAN))
    else $error("booked count changed outside a booking");

  // A booking always reports booked on the next result
  a_book_status: assert property (@(posedge clk) disable iff (rst)
    do_book |=> (pend_status == irt_pkg::ST_BOOKED) && (state == S_FINISH))
    else $error("booking without booked status");

  // A new request is never popped while a scan read is still in flight
  a_pop_clean: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !rd_pending || (state == S_IDLE))
    else $error("pop during active scan");
`endif

endmodule

FILE: rtl/interval_reservation_table_top.sv
// Top level of the interval reservation table: front, queue and back end.
//
// Usage:
//   Request channel: in_valid / in_stall with start_time and end_time, a
//   half-open interval [start_time, end_time). A beat is taken at a rising
//   edge with in_valid high and in_stall low.
//   Result channel: out_valid / out_stall with status (0 booked, 1 overlaps
//   a stored interval, 2 table full, 3 start not below end). One result
//   beat per request, in request order.
//   Order: a request passes the front register and the queue; the back end
//   then pops it, reads the N stored intervals from memory one per cycle,
//   waits for the last registered read, decides and hands off the result.
//   Malformed requests skip the scan. The back end takes a new request only
//   after the last one's result is handed off, so throughput is set by the
//   one-read-per-cycle scan of the interval memory and by result stalls.
//   Reset (rst, synchronous) empties the table, the queue and the front
//   register; memory contents are not cleared, and entries beyond the count
//   are never compared. When the receiver stalls, the result register holds;
//   the back end then waits, the queue fills and in_stall rises.
module interval_reservation_table_top #(
  parameter int ENTRIES   = 64,
  parameter int TIME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [TIME_BITS-1:0] start_time,
  input  logic [TIME_BITS-1:0] end_time,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           status
);

  localparam int QW = 2 * TIME_BITS + 1;

  logic          push;
  logic [QW-1:0] push_data;
  logic          q_full;
  logic          q_pop;
  logic          q_avail;
  logic [QW-1:0] q_data;

  irt_front #(
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .start_time (start_time),
    .end_time   (end_time),
    .push       (push),
    .push_data  (push_data),
    .q_full     (q_full)
  );

  irt_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .avail     (q_avail),
    .pop_data  (q_data)
  );

  irt_back #(
    .ENTRIES   (ENTRIES),
    .TIME_BITS (TIME_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_avail   (q_avail),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status)
  );

endmodule

FILE: sim/irt_checker.sv
// Channel monitor and status predictor for the interval reservation table.
module irt_checker #(
  parameter int ENTRIES   = 64,
  parameter int TIME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [TIME_BITS-1:0] start_time,
  input  logic [TIME_BITS-1:0] end_time,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [1:0]           status,
  output int                   errors,
  output int                   pending,
  output int                   n_booked,
  output int                   n_conflict,
  output int                   n_full,
  output int                   n_malformed
);

  // Shadow copy of the booked intervals
  logic [TIME_BITS-1:0] held_lo [ENTRIES];
  logic [TIME_BITS-1:0] held_hi [ENTRIES];
  int                   held_count;

  // Statuses owed by the block, oldest first
  irt_pkg::status_t status_due [$];

  // Decide one request against the shadow table and book it if it fits
  function automatic irt_pkg::status_t reserve(input logic [TIME_BITS-1:0] s,
                                               input logic [TIME_BITS-1:0] e);
    irt_pkg::status_t verdict;
    logic             clash;
    clash = 1'b0;
    if (s >= e) begin
      verdict = irt_pkg::ST_MALFORMED;
    end else begin
      for (int i = 0; i < held_count; i++) begin
        if (s < held_hi[i] && held_lo[i] < e) clash = 1'b1;
      end
      if (clash) begin
        verdict = irt_pkg::ST_CONFLICT;
      end else if (held_count >= ENTRIES) begin
        verdict = irt_pkg::ST_FULL;
      end else begin
        held_lo[held_count] = s;
        held_hi[held_count] = e;
        held_count++;
        verdict = irt_pkg::ST_BOOKED;
      end
    end
    return verdict;
  endfunction

  // Results are checked before the same edge's request is queued;
  // a request can never come out on the edge it went in
  always @(posedge clk) begin
    irt_pkg::status_t want;
    if (rst) begin
      status_due.delete();
      held_count  = 0;
      errors      = 0;
      n_booked    = 0;
      n_conflict  = 0;
      n_full      = 0;
      n_malformed = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (status_due.size() == 0) begin
          errors++;
          $display("%0t: status beat %0d with no request outstanding", $time, status);
        end else begin
          want = status_due.pop_front();
          if (status !== want) begin
            errors++;
            $display("%0t: status mismatch: expected %0d (%s), got %0d",
                     $time, want, want.name(), status);
          end
          case (want)
            irt_pkg::ST_BOOKED:   n_booked++;
            irt_pkg::ST_CONFLICT: n_conflict++;
            irt_pkg::ST_FULL:     n_full++;
            default:              n_malformed++;
          endcase
        end
      end
      if (in_valid && !in_stall) status_due.push_back(reserve(start_time, end_time));
    end
    pending = status_due.size();
  end

endmodule

FILE: sim/tb_top.sv
// Testbench top for the interval reservation table: clock, reset, stimulus and verdict.
module tb_top;

  localparam int ENT = 64;
  localparam int TB  = 32;
  localparam logic [TB-1:0] TOP = '1;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [TB-1:0] start_time = '0;
  logic [TB-1:0] end_time = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [1:0]    status;

  int errors, pending, n_booked, n_conflict, n_full, n_malformed;

  // Stimulus bookkeeping: recent intervals placed in fresh territory
  logic [TB-1:0] fresh_lo [$];
  logic [TB-1:0] fresh_hi [$];
  logic [TB-1:0] cursor = 32'h1000_0000;
  bit            calm = 1'b0;
  int            stall_left = 0;

  interval_reservation_table_top #(
    .ENTRIES  (ENT),
    .TIME_BITS(TB)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .start_time(start_time),
    .end_time  (end_time),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status)
  );

  irt_checker #(
    .ENTRIES  (ENT),
    .TIME_BITS(TB)
  ) u_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .start_time (start_time),
    .end_time   (end_time),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .errors     (errors),
    .pending    (pending),
    .n_booked   (n_booked),
    .n_conflict (n_conflict),
    .n_full     (n_full),
    .n_malformed(n_malformed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver back-pressure, held for random stretches
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (calm || rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 35);
      stall_left = pick_gap();
    end
  end

  // Drive one request beat and hold it until taken
  task automatic send_request(input logic [TB-1:0] s, input logic [TB-1:0] e);
    int gap;
    gap = calm ? 0 : pick_gap();
    start_time <= s;
    end_time   <= e;
    in_valid   <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Hold off the sender until every status is back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // One random request: fresh slots, probes around earlier ones, noise, edges
  task automatic send_random();
    logic [TB-1:0] s, e, lo, hi;
    int            r, k, w;
    r = $urandom_range(99);
    w = $urandom_range(1, 10);
    if (r < 5 || fresh_lo.size() == 0) begin
      s = cursor + $urandom_range(1, 8);
      e = s + $urandom_range(1, 64);
      cursor = e;
      fresh_lo.push_back(s);
      fresh_hi.push_back(e);
      if (fresh_lo.size() > 16) begin
        void'(fresh_lo.pop_front());
        void'(fresh_hi.pop_front());
      end
    end else if (r < 65) begin
      k  = $urandom_range(fresh_lo.size() - 1);
      lo = fresh_lo[k];
      hi = fresh_hi[k];
      case ($urandom_range(7))
        0: begin s = lo;     e = hi;     end  // exact repeat
        1: begin s = hi - 1; e = hi + w; end  // shares last point
        2: begin s = lo - w; e = lo + 1; end  // shares first point
        3: begin s = hi;     e = hi + w; end  // touches the end
        4: begin s = lo - w; e = lo;     end  // touches the start
        5: begin s = lo - 1; e = hi + 1; end  // swallows it
        6: begin s = hi;     e = lo;     end  // reversed
        default: begin s = lo; e = lo; end    // empty
      endcase
    end else if (r < 80) begin
      s = $urandom;
      e = $urandom;
    end else if (r < 90) begin
      e = $urandom;
      s = e + $urandom_range(0, 3);
    end else begin
      case ($urandom_range(3))
        0: begin s = '0;      e = w;        end
        1: begin s = TOP - w; e = TOP;      end
        2: begin s = '0;      e = TOP;      end
        default: begin s = TOP; e = $urandom; end
      endcase
    end
    send_request(s, e);
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: malformed forms, range extremes, touching and straddling edges
    send_request(32'd0, 32'd0);
    send_request(TOP, TOP);
    send_request(TOP, 32'd0);
    send_request(32'd5, 32'd4);
    send_request(32'd0, 32'd1);
    send_request(32'd0, 32'd1);
    send_request(32'd1, 32'd2);
    send_request(TOP - 1, TOP);
    send_request(TOP - 2, TOP);
    send_request(32'd0, TOP);
    send_request(32'd100, 32'd200);
    send_request(32'd200, 32'd300);
    send_request(32'd50, 32'd100);
    send_request(32'd199, 32'd201);
    send_request(32'd150, 32'd160);
    send_request(32'd300, 32'd301);
    send_request(32'd99, 32'd100);
    send_request(32'h5555_5555, 32'hAAAA_AAAA);
    send_request(32'hAAAA_AAAA, 32'hAAAA_AAAB);
    drain();

    // Random blocks; every third one runs with no idling on either side
    for (int blk = 0; blk < 6; blk++) begin
      calm = (blk % 3 == 1);
      repeat (300) send_random();
      drain();
    end
    calm = 1'b0;

    repeat (100) @(negedge clk);
    $display("Covered %0d requests from empty to full table: %0d booked, %0d overlapping,",
             n_booked + n_conflict + n_full + n_malformed, n_booked, n_conflict);
    $display("%0d refused as full, %0d malformed, under random gaps and back-pressure",
             n_full, n_malformed);
    if (errors == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #30_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
